FILE: rtl/core/bank_switch_mapper_with_scanline_irq_assert.svh
// Assertion macros shared by the mapper RTL.
// Needs nothing else. Define ASSERT_OFF to compile the checks out.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication check.
`define BSM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define BSM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg)
`define BSM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
// No dependencies; compiled before the interfaces and modules.
package bsm_pkg;

  localparam int PRG_BANKS_MAX = 64;
  localparam int CHR_BANKS_MAX = 256;
  localparam int PRG_CNT_W     = 7;
  localparam int CHR_CNT_W     = 9;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RESET = PRG_CNT_W'(64);
  localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RESET = CHR_CNT_W'(256);

  // Configuration register index, taken from paddr[2].
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_COUNT = 1'b1;

  localparam logic [15:0] CART_BASE = 16'h4020;

  typedef logic [15:0] bus_addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [18:0] map_addr_t;

  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PPU_READ  = 2'd2,
    OP_PPU_PEEK  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_PRG_ROM   = 3'd1,
    TGT_RAM_READ  = 3'd2,
    TGT_RAM_WRITE = 3'd3,
    TGT_CHR_ROM   = 3'd4
  } target_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } bsm_rem_stat_t;

endpackage

FILE: rtl/core/bsm_in_if.sv
// Access request channel: valid/ready handshake plus the bus access payload.
// Depends on bsm_pkg.
interface bsm_in_if;
  logic              valid;
  logic              ready;
  bsm_pkg::opcode_t  opcode;
  bsm_pkg::bus_addr_t bus_address;
  bsm_pkg::byte_t    write_byte;

  modport source (output valid, output opcode, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input opcode, input bus_address, input write_byte,
                  output ready);
endinterface

FILE: rtl/core/bsm_out_if.sv
// Mapping result channel: valid/ready handshake plus the result payload.
// Depends on bsm_pkg.
interface bsm_out_if;
  logic                valid;
  logic                ready;
  logic                claimed;
  bsm_pkg::target_t    target;
  bsm_pkg::map_addr_t  mapped_address;
  bsm_pkg::byte_t      ram_write_byte;
  logic                irq_pending;
  logic                hmirror;

  modport source (output valid, output claimed, output target, output mapped_address,
                  output ram_write_byte, output irq_pending, output hmirror,
                  input ready);
  modport sink   (input valid, input claimed, input target, input mapped_address,
                  input ram_write_byte, input irq_pending, input hmirror,
                  output ready);
endinterface

FILE: rtl/core/bsm_rem_unit.sv
// Restoring remainder unit: 8-bit dividend modulo a 9-bit divisor, one bit per cycle.
// Depends on bsm_pkg for the status struct.
module bsm_rem_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [7:0]             dividend,
  input  logic [8:0]             divisor,
  output bsm_pkg::bsm_rem_stat_t stat,
  output logic [7:0]             remainder
);
  import bsm_pkg::*;

  logic       busy;
  logic       done;
  logic [2:0] step;
  logic [7:0] rem;
  logic [7:0] dvd;
  logic [8:0] dvs;
  logic [8:0] trial;
  logic       fits;

  // Partial remainder stays below the divisor, so both paths fit in 8 bits.
  assign trial = {rem, dvd[7]};
  assign fits  = (trial >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? 8'(trial - dvs) : trial[7:0];
        dvd  <= {dvd[6:0], 1'b0};
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

FILE: rtl/core/bank_switch_mapper_with_scanline_irq.sv
// Bank switch mapper with scanline IRQ counter: one result beat per request beat.
// A request passes through CALC and DONE, where the result is registered out;
// a bank register write also waits in DIV while the bit-serial remainder unit
// runs 8 steps. A new request is taken only in IDLE or in DONE.
// Reset (rst, synchronous): all mapper registers and the IRQ counter clear to
// zero, bank counts return to 64 program and 256 character banks.
`include "bank_switch_mapper_with_scanline_irq_assert.svh"

module bank_switch_mapper_with_scanline_irq (
  input  logic                           clk,
  input  logic                           rst,
  bsm_in_if.sink                         req,
  bsm_out_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bsm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bsm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bsm_pkg::*;

  // The sequencer: CALC does all single-cycle work, DIV waits on the shared
  // remainder unit, DONE hands the result to the output register.
  typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_DONE} state_t;

  state_t state;

  // Configuration registers.
  logic [PRG_CNT_W-1:0] prg_bank_count;
  logic [CHR_CNT_W-1:0] chr_bank_count;

  // Mapper state.
  logic [7:0] bank_mode;
  logic [7:0] chr_regs [6];
  logic [5:0] prg_regs [2];
  logic       mirror_mode;
  logic [7:0] wram_ctl;
  logic [7:0] irq_period;
  logic [7:0] irq_count;
  logic       irq_rearm;
  logic       irq_enabled;
  logic       irq_line;
  logic       last_a12;

  // The request held while it is processed.
  opcode_t    item_op;
  bus_addr_t  item_addr;
  byte_t      item_data;

  // Result fields computed in CALC and held until DONE.
  logic       res_claimed;
  target_t    res_target;
  map_addr_t  res_maddr;
  byte_t      res_wbyte;

  logic       accept;
  logic       out_free;

  // ------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high, so there are no wait states.
  // ------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_bank_count <= CHR_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PRG_COUNT) begin
        prg_bank_count <= pwdata[PRG_CNT_W-1:0];
      end else begin
        chr_bank_count <= pwdata[CHR_CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHR_COUNT) begin
      prdata = APB_DATA_W'(chr_bank_count);
    end else begin
      prdata = APB_DATA_W'(prg_bank_count);
    end
  end

  // The bank counts in use are clamped so the remainder unit never sees zero.
  logic [PRG_CNT_W-1:0] eff_prg;
  logic [CHR_CNT_W-1:0] eff_chr;
  logic [PRG_CNT_W-1:0] eff_prg_m1;
  logic [PRG_CNT_W-1:0] eff_prg_m2;

  always_comb begin
    if (prg_bank_count < PRG_CNT_W'(2)) begin
      eff_prg = PRG_CNT_W'(2);
    end else if (prg_bank_count > PRG_CNT_W'(PRG_BANKS_MAX)) begin
      eff_prg = PRG_CNT_W'(PRG_BANKS_MAX);
    end else begin
      eff_prg = prg_bank_count;
    end
    if (chr_bank_count < CHR_CNT_W'(8)) begin
      eff_chr = CHR_CNT_W'(8);
    end else if (chr_bank_count > CHR_CNT_W'(CHR_BANKS_MAX)) begin
      eff_chr = CHR_CNT_W'(CHR_BANKS_MAX);
    end else begin
      eff_chr = chr_bank_count;
    end
  end

  assign eff_prg_m1 = eff_prg - PRG_CNT_W'(1);
  assign eff_prg_m2 = eff_prg - PRG_CNT_W'(2);

  // ------------------------------------------------------------------
  // Program ROM window. The E000 slot is fixed to the last bank, A000 switchable;
  // PRG mode swaps 8000 and C000 between switchable and second-to-last bank.
  // ------------------------------------------------------------------
  logic [5:0] prg_bank;

  always_comb begin
    unique case (item_addr[14:13])
      2'b01:   prg_bank = prg_regs[1];
      2'b11:   prg_bank = eff_prg_m1[5:0];
      2'b00:   prg_bank = bank_mode[6] ? eff_prg_m2[5:0] : prg_regs[0];
      default: prg_bank = bank_mode[6] ? prg_regs[0] : eff_prg_m2[5:0];
    endcase
  end

  // ------------------------------------------------------------------
  // Character ROM window. Bit 7 of the bank mode swaps the two pattern
  // tables. The low half is two 2K pairs, the high half four 1K banks.
  // ------------------------------------------------------------------
  logic       chr_a12;
  logic [2:0] chr_idx;
  logic [7:0] chr_sel;
  logic [7:0] chr_bank;

  assign chr_a12 = item_addr[12] ^ bank_mode[7];

  always_comb begin
    if (chr_a12) begin
      chr_idx = {1'b1, item_addr[11:10]} - 3'd2;
    end else begin
      chr_idx = {2'b00, item_addr[11]};
    end
    chr_sel = chr_regs[chr_idx];
    if (chr_a12) begin
      chr_bank = chr_sel;
    end else begin
      chr_bank = {chr_sel[7:1], item_addr[10]};
    end
  end

  // ------------------------------------------------------------------
  // Access decode for the held request.
  // ------------------------------------------------------------------
  logic    ram_en;
  logic    ram_wp;
  logic    in_ram;
  logic    claimed_c;
  target_t target_c;
  map_addr_t maddr_c;
  byte_t   wbyte_c;
  logic    reg_wr;

  assign ram_en = wram_ctl[7];
  assign ram_wp = wram_ctl[6];
  assign in_ram = (item_addr[15:13] == 3'b011);
  assign reg_wr = (item_op == OP_CPU_WRITE) && item_addr[15];

  always_comb begin
    claimed_c = 1'b0;
    target_c  = TGT_NONE;
    maddr_c   = '0;
    wbyte_c   = '0;
    unique case (item_op)
      OP_CPU_READ: begin
        claimed_c = (item_addr >= CART_BASE);
        if (item_addr[15]) begin
          target_c = TGT_PRG_ROM;
          maddr_c  = {prg_bank, item_addr[12:0]};
        end else if (in_ram && ram_en) begin
          target_c = TGT_RAM_READ;
          maddr_c  = {6'b000000, item_addr[12:0]};
        end
      end
      OP_CPU_WRITE: begin
        claimed_c = (item_addr >= CART_BASE);
        if (!item_addr[15] && in_ram && ram_en && !ram_wp) begin
          target_c = TGT_RAM_WRITE;
          maddr_c  = {6'b000000, item_addr[12:0]};
          wbyte_c  = item_data;
        end
      end
      default: begin
        // PPU read or peek: only the pattern table space is ours.
        if (item_addr[15:13] == 3'b000) begin
          claimed_c = 1'b1;
          target_c  = TGT_CHR_ROM;
          maddr_c   = {1'b0, chr_bank, item_addr[9:0]};
        end
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Scanline counter. A real PPU read clocks it on a rising edge of A12:
  // it reloads from the latch when empty or when a reload is armed, and
  // otherwise counts down. Reaching zero while enabled raises the IRQ.
  // ------------------------------------------------------------------
  logic       irq_tick;
  logic [7:0] irq_count_next;

  assign irq_tick = (item_op == OP_PPU_READ) && !last_a12 && item_addr[12];

  always_comb begin
    if ((irq_count == 8'd0) || irq_rearm) begin
      irq_count_next = irq_period;
    end else begin
      irq_count_next = irq_count - 8'd1;
    end
  end

  // ------------------------------------------------------------------
  // Shared remainder unit. A bank register write reduces its data modulo
  // the character or program bank count, chosen by the register select.
  // ------------------------------------------------------------------
  logic          rem_start;
  logic          sel_chr;
  logic [8:0]    rem_divisor;
  bsm_rem_stat_t rem_stat;
  logic [7:0]    rem_value;

  assign sel_chr     = (bank_mode[2:0] < 3'd6);
  assign rem_divisor = sel_chr ? eff_chr : {2'b00, eff_prg};
  assign rem_start   = (state == S_CALC) && reg_wr && (item_addr[14:13] == 2'b00)
                       && item_addr[0];

  bsm_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (item_data),
    .divisor   (rem_divisor),
    .stat      (rem_stat),
    .remainder (rem_value)
  );

  // ------------------------------------------------------------------
  // Handshake. A new request is taken in IDLE, or in DONE in the same cycle
  // that the finished result moves into the output register; while a result
  // still waits on the far side, DONE holds and no new request is taken.
  // ------------------------------------------------------------------
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp.valid   <= 1'b0;
      bank_mode   <= '0;
      chr_regs    <= '{default: '0};
      prg_regs    <= '{default: '0};
      mirror_mode <= 1'b0;
      wram_ctl    <= '0;
      irq_period  <= '0;
      irq_count   <= '0;
      irq_rearm   <= 1'b0;
      irq_enabled <= 1'b0;
      irq_line    <= 1'b0;
      last_a12    <= 1'b0;
    end else begin
      // In DONE the output register is refilled below instead.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_op   <= req.opcode;
            item_addr <= req.bus_address;
            item_data <= req.write_byte;
            state     <= S_CALC;
          end
        end
        S_CALC: begin
          res_claimed <= claimed_c;
          res_target  <= target_c;
          res_maddr   <= maddr_c;
          res_wbyte   <= wbyte_c;
          if (item_op == OP_PPU_READ) begin
            last_a12 <= item_addr[12];
          end
          if (irq_tick) begin
            irq_count <= irq_count_next;
            irq_rearm <= 1'b0;
            if ((irq_count_next == 8'd0) && irq_enabled) begin
              irq_line <= 1'b1;
            end
          end
          if (reg_wr) begin
            unique case (item_addr[14:13])
              2'b00: begin
                // Odd address goes through the remainder unit instead.
                if (!item_addr[0]) begin
                  bank_mode <= item_data;
                end
              end
              2'b01: begin
                if (item_addr[0]) begin
                  wram_ctl <= item_data;
                end else begin
                  mirror_mode <= item_data[0];
                end
              end
              2'b10: begin
                if (item_addr[0]) begin
                  irq_rearm <= 1'b1;
                end else begin
                  irq_period <= item_data;
                end
              end
              default: begin
                irq_enabled <= item_addr[0];
                if (!item_addr[0]) begin
                  irq_line <= 1'b0;
                end
              end
            endcase
          end
          state <= rem_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (rem_stat.done) begin
            if (sel_chr) begin
              chr_regs[bank_mode[2:0]] <= rem_value;
            end else begin
              prg_regs[bank_mode[0]] <= rem_value[5:0];
            end
            state <= S_DONE;
          end
        end
        default: begin
          // S_DONE: IRQ level and mirroring reflect this access's updates.
          if (out_free) begin
            rsp.valid          <= 1'b1;
            rsp.claimed        <= res_claimed;
            rsp.target         <= res_target;
            rsp.mapped_address <= res_maddr;
            rsp.ram_write_byte <= res_wbyte;
            rsp.irq_pending    <= irq_line;
            rsp.hmirror        <= mirror_mode;
            if (accept) begin
              item_op   <= req.opcode;
              item_addr <= req.bus_address;
              item_data <= req.write_byte;
              state     <= S_CALC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Checks.
  // ------------------------------------------------------------------
  `BSM_ASSERT_IMPL(a_irq_rise_calc, clk, rst, $rose(irq_line), $past(state) == S_CALC,
    "IRQ line rose outside request processing")
  `BSM_ASSERT_IMPL(a_rem_start_idle, clk, rst, rem_start, !rem_stat.busy,
    "Remainder unit restarted while busy")
  `BSM_ASSERT_IMPL(a_rem_done_div, clk, rst, rem_stat.done, state == S_DIV,
    "Remainder finished with no bank write waiting")
  `BSM_ASSERT_NEXT(a_div_entry, clk, rst, rem_start, state == S_DIV,
    "Bank write did not wait on the remainder unit")
  `BSM_ASSERT_IMPL(a_target_claimed, clk, rst, rsp.valid && (rsp.target != TGT_NONE),
    rsp.claimed, "Mapped access not claimed")

endmodule

FILE: dv/bank_switch_mapper_with_scanline_irq_tb.sv
// Testbench for the bank switch mapper with scanline IRQ counter.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if and the mapper RTL; nothing else.
// Checks every result beat against an in-bench model of the mapper state.
`timescale 1ns / 100ps

module bank_switch_mapper_with_scanline_irq_tb;
  import bsm_pkg::*;

  // Run length guard and the quiet time after the last result.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 30;
  // Random items per bank count setting, and the settings themselves.
  // The list covers the reset values, both minimums, zero and all-ones
  // (which saturate) and an odd character count.
  localparam int PHASE_ITEMS = 80;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_PRG[NUM_PHASES] = '{64, 2, 0, 127, 37, 13};
  localparam int PHASE_CHR[NUM_PHASES] = '{256, 8, 0, 511, 100, 9};

  // CPU and PPU address map.
  localparam bus_addr_t RAM_BASE      = 16'h6000;
  localparam bus_addr_t BANK_REG_BASE = 16'h8000;
  localparam bus_addr_t MIRROR_BASE   = 16'hA000;
  localparam bus_addr_t IRQ_BASE      = 16'hC000;
  localparam bus_addr_t IRQ_EN_BASE   = 16'hE000;
  localparam bus_addr_t PPU_TOP       = 16'h2000;
  localparam bus_addr_t PPU_A12       = 16'h1000;

  typedef struct {
    logic      claimed;
    target_t   target;
    map_addr_t mapped_address;
    byte_t     ram_write_byte;
    logic      irq_pending;
    logic      hmirror;
  } mapping_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  bsm_in_if  req();
  bsm_out_if rsp();

  bank_switch_mapper_with_scanline_irq u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shared run state: error count, expected mappings in acceptance order,
  // and the knobs that shape idling on both sides.
  int         errors = 0;
  int         items_sent = 0;
  int         beats_seen = 0;
  int         cycle_count = 0;
  mapping_t   pending_maps[$];
  bit         no_idle = 1'b0;
  int         hold_len = 0;

  // Mapper model state. Bank counts start at their reset values.
  logic [PRG_CNT_W-1:0] cfg_prg_cnt = PRG_COUNT_RESET;
  logic [CHR_CNT_W-1:0] cfg_chr_cnt = CHR_COUNT_RESET;
  byte_t m_bank_sel = '0;
  byte_t m_chr_bank[6] = '{default: '0};
  byte_t m_prg_bank[2] = '{default: '0};
  logic  m_mirror = 1'b0;
  byte_t m_ram_ctl = '0;
  byte_t m_irq_period = '0;
  byte_t m_irq_cnt = '0;
  logic  m_irq_rearm = 1'b0;
  logic  m_irq_en = 1'b0;
  logic  m_irq_line = 1'b0;
  logic  m_a12 = 1'b0;

  // Bank counts as the mapper uses them: clamped so the modulo never
  // sees zero and never exceeds the largest cartridge.
  function automatic int prg_banks();
    int n;
    n = cfg_prg_cnt;
    if (n < 2) n = 2;
    if (n > PRG_BANKS_MAX) n = PRG_BANKS_MAX;
    return n;
  endfunction

  function automatic int chr_bank_total();
    int n;
    n = cfg_chr_cnt;
    if (n < 8) n = 8;
    if (n > CHR_BANKS_MAX) n = CHR_BANKS_MAX;
    return n;
  endfunction

  // 8K program windows. 0xA000 always follows R7 and 0xE000 the last bank;
  // the PRG mode bit swaps R6 and the second-to-last bank between 0x8000
  // and 0xC000.
  function automatic map_addr_t prg_rom_addr(bus_addr_t a);
    logic [1:0] slot;
    int bank;
    slot = a[14:13];
    if (slot == 2'd1) bank = m_prg_bank[1];
    else if (slot == 2'd3) bank = prg_banks() - 1;
    else if ((slot == 2'd0) == (m_bank_sel[6] == 1'b0)) bank = m_prg_bank[0];
    else bank = prg_banks() - 2;
    return map_addr_t'((bank << 13) | a[12:0]);
  endfunction

  // 1K character windows. The inversion bit swaps the two pattern tables;
  // the low table is built from two 2K pairs whose low bit follows the slot.
  function automatic map_addr_t chr_rom_addr(bus_addr_t a);
    bus_addr_t  v;
    logic [2:0] slot;
    byte_t      bank;
    v = a;
    if (m_bank_sel[7]) v[12] = ~v[12];
    slot = v[12:10];
    if (slot < 3'd4) begin
      bank = m_chr_bank[slot[1]];
      bank[0] = slot[0];
    end else begin
      bank = m_chr_bank[int'(slot) - 2];
    end
    return map_addr_t'({bank, v[9:0]});
  endfunction

  // One clock of the scanline counter: reload when empty or armed,
  // otherwise count down; raise the line on reaching zero while enabled.
  task automatic clock_scanline();
    if (m_irq_cnt == 8'd0 || m_irq_rearm) begin
      m_irq_rearm = 1'b0;
      m_irq_cnt = m_irq_period;
    end else begin
      m_irq_cnt = m_irq_cnt - 8'd1;
    end
    if (m_irq_cnt == 8'd0 && m_irq_en) m_irq_line = 1'b1;
  endtask

  // Mapper register writes at 0x8000 and above, decoded by window and
  // by the low address bit.
  task automatic write_mapper_reg(bus_addr_t a, byte_t d);
    logic [2:0] sel;
    sel = m_bank_sel[2:0];
    if (a < MIRROR_BASE) begin
      if (!a[0]) m_bank_sel = d;
      else if (sel < 3'd6) m_chr_bank[sel] = byte_t'(d % chr_bank_total());
      else m_prg_bank[int'(sel) - 6] = byte_t'(d % prg_banks());
    end else if (a < IRQ_BASE) begin
      if (!a[0]) m_mirror = d[0];
      else m_ram_ctl = d;
    end else if (a < IRQ_EN_BASE) begin
      if (!a[0]) m_irq_period = d;
      else m_irq_rearm = 1'b1;
    end else begin
      m_irq_en = a[0];
      if (!a[0]) m_irq_line = 1'b0;
    end
  endtask

  // Works out the result of one accepted access, updates the model state
  // and queues the expected mapping.
  task automatic map_access(opcode_t op, bus_addr_t a, byte_t d);
    mapping_t m;
    logic     a12;
    m = '{claimed: 1'b0, target: TGT_NONE, mapped_address: '0, ram_write_byte: '0,
          irq_pending: 1'b0, hmirror: 1'b0};
    case (op)
      OP_CPU_READ: begin
        m.claimed = (a >= CART_BASE);
        if (a >= BANK_REG_BASE) begin
          m.target = TGT_PRG_ROM;
          m.mapped_address = prg_rom_addr(a);
        end else if (a >= RAM_BASE && m_ram_ctl[7]) begin
          m.target = TGT_RAM_READ;
          m.mapped_address = map_addr_t'(a[12:0]);
        end
      end
      OP_CPU_WRITE: begin
        m.claimed = (a >= CART_BASE);
        if (a >= BANK_REG_BASE) begin
          write_mapper_reg(a, d);
        end else if (a >= RAM_BASE && m_ram_ctl[7] && !m_ram_ctl[6]) begin
          m.target = TGT_RAM_WRITE;
          m.mapped_address = map_addr_t'(a[12:0]);
          m.ram_write_byte = d;
        end
      end
      default: begin
        // Only real PPU reads feed the A12 edge detector; peeks leave it alone.
        if (op == OP_PPU_READ) begin
          a12 = a[12];
          if (!m_a12 && a12) clock_scanline();
          m_a12 = a12;
        end
        if (a < PPU_TOP) begin
          m.claimed = 1'b1;
          m.target = TGT_CHR_ROM;
          m.mapped_address = chr_rom_addr(a);
        end
      end
    endcase
    m.irq_pending = m_irq_line;
    m.hmirror = m_mirror;
    pending_maps.push_back(m);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("beat %0d: %s got 0x%0h, expected 0x%0h", beats_seen, what, got, want);
    errors++;
  endtask

  // Compares the result beat now on the channel with the oldest expectation.
  task automatic check_result();
    mapping_t e;
    if (pending_maps.size() == 0) begin
      report_mismatch("beat with nothing expected, target", rsp.target, 0);
    end else begin
      e = pending_maps.pop_front();
      if (rsp.claimed !== e.claimed)
        report_mismatch("claimed", rsp.claimed, e.claimed);
      if (rsp.target !== e.target)
        report_mismatch("target", rsp.target, e.target);
      if (rsp.mapped_address !== e.mapped_address)
        report_mismatch("mapped_address", rsp.mapped_address, e.mapped_address);
      if (rsp.ram_write_byte !== e.ram_write_byte)
        report_mismatch("ram_write_byte", rsp.ram_write_byte, e.ram_write_byte);
      if (rsp.irq_pending !== e.irq_pending)
        report_mismatch("irq_pending", rsp.irq_pending, e.irq_pending);
      if (rsp.hmirror !== e.hmirror)
        report_mismatch("hmirror", rsp.hmirror, e.hmirror);
    end
    beats_seen++;
  endtask

  // Sends one access beat. Called and returning at a rising edge. Valid stays
  // high into the next call so back-to-back beats need no extra assignment.
  // Ready is sampled on the falling edge, where it is settled.
  task automatic send_access(opcode_t op, bus_addr_t a, byte_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.opcode      <= op;
    req.bus_address <= a;
    req.write_byte  <= d;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    map_access(op, a, d);
    items_sent++;
  endtask

  // Drops valid and waits until every expected beat has come back.
  task automatic wait_drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
  endtask

  // Writes one bank count register over APB, then reads it back.
  task automatic write_bank_count(logic idx, int value);
    logic [APB_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_PRG_COUNT) cfg_prg_cnt = PRG_CNT_W'(value);
    else cfg_chr_cnt = CHR_CNT_W'(value);
    want = (idx == REG_PRG_COUNT) ? APB_DATA_W'(cfg_prg_cnt) : APB_DATA_W'(cfg_chr_cnt);
    // Read phase follows directly; psel stays high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== want) report_mismatch("bank count readback", prdata, want);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random address in a register window, with the even/odd bit chosen.
  function automatic bus_addr_t reg_addr(bus_addr_t base, logic odd);
    return base | (bus_addr_t'($urandom) & 16'h1FFE) | bus_addr_t'(odd);
  endfunction

  // CPU space edges: below the cartridge, the unmapped gap, RAM while it is
  // still disabled, and the very top of program space.
  task automatic test_cpu_windows();
    send_access(OP_CPU_READ, 16'h0000, 8'h00);
    send_access(OP_CPU_WRITE, 16'h401F, 8'hFF);
    send_access(OP_CPU_READ, CART_BASE, 8'h00);
    send_access(OP_CPU_READ, RAM_BASE, 8'h00);
    send_access(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
    send_access(OP_CPU_READ, 16'hFFFF, 8'h00);
  endtask

  // Bank registers with values past the bank count, PRG mode swapped and
  // CHR inversion on; then PPU peeks in both tables and at 0x2000.
  task automatic test_bank_select();
    send_access(OP_CPU_WRITE, BANK_REG_BASE, 8'h46);
    send_access(OP_CPU_WRITE, BANK_REG_BASE | 16'h1, 8'hFF);
    send_access(OP_CPU_WRITE, BANK_REG_BASE, 8'h07);
    send_access(OP_CPU_WRITE, 16'h9FFF, 8'h81);
    send_access(OP_CPU_READ, BANK_REG_BASE, 8'h00);
    send_access(OP_CPU_READ, 16'hC123, 8'h00);
    send_access(OP_CPU_WRITE, BANK_REG_BASE, 8'h80);
    send_access(OP_CPU_WRITE, BANK_REG_BASE | 16'h1, 8'hFF);
    send_access(OP_PPU_PEEK, PPU_A12, 8'h00);
    send_access(OP_PPU_PEEK, 16'h0400, 8'h00);
    send_access(OP_PPU_PEEK, PPU_TOP, 8'h00);
  endtask

  // Work RAM enabled, written, read, then write protected, plus mirroring.
  task automatic test_work_ram();
    send_access(OP_CPU_WRITE, MIRROR_BASE | 16'h1, 8'h80);
    send_access(OP_CPU_WRITE, RAM_BASE, 8'hA5);
    send_access(OP_CPU_READ, 16'h7FFF, 8'h00);
    send_access(OP_CPU_WRITE, MIRROR_BASE | 16'h1, 8'hC0);
    send_access(OP_CPU_WRITE, RAM_BASE | 16'h1, 8'h5A);
    send_access(OP_CPU_WRITE, MIRROR_BASE, 8'h01);
  endtask

  // Latch of one: the first A12 rise reloads, the second reaches zero and
  // raises the line; a peek must not clock; a disable write clears it.
  task automatic test_scanline_irq();
    send_access(OP_CPU_WRITE, IRQ_BASE, 8'h01);
    send_access(OP_CPU_WRITE, IRQ_BASE | 16'h1, 8'h00);
    send_access(OP_CPU_WRITE, IRQ_EN_BASE | 16'h1, 8'h00);
    send_access(OP_PPU_READ, PPU_A12, 8'h00);
    send_access(OP_PPU_READ, 16'h0000, 8'h00);
    send_access(OP_PPU_PEEK, 16'h1FFF, 8'h00);
    send_access(OP_PPU_READ, 16'h3FFF, 8'h00);
    send_access(OP_CPU_WRITE, IRQ_EN_BASE, 8'h00);
  endtask

  // One random stretch of traffic. Most stretches are the sequences a game
  // really issues (bank select pairs, IRQ setup followed by scanlines, RAM
  // enable then RAM traffic); the rest is plain noise.
  task automatic random_round();
    int        kind;
    int        n;
    bus_addr_t a;
    byte_t     d;
    kind = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 7) == 0);
    case (kind)
      0, 1: begin
        send_access(OP_CPU_WRITE, reg_addr(BANK_REG_BASE, 1'b0), byte_t'($urandom));
        send_access(OP_CPU_WRITE, reg_addr(BANK_REG_BASE, 1'b1), byte_t'($urandom));
        send_access(OP_PPU_PEEK, bus_addr_t'($urandom) & 16'h1FFF, byte_t'($urandom));
        send_access(OP_CPU_READ, BANK_REG_BASE | bus_addr_t'($urandom), byte_t'($urandom));
      end
      2, 3: begin
        if ($urandom_range(0, 1))
          send_access(OP_CPU_WRITE, reg_addr(IRQ_BASE, 1'b0), byte_t'($urandom_range(0, 6)));
        if ($urandom_range(0, 1))
          send_access(OP_CPU_WRITE, reg_addr(IRQ_BASE, 1'b1), byte_t'($urandom));
        send_access(OP_CPU_WRITE, reg_addr(IRQ_EN_BASE, ($urandom_range(0, 3) != 0)),
                    byte_t'($urandom));
        // Pattern fetches alternate tables, so A12 rises every other read.
        n = $urandom_range(4, 16);
        for (int i = 0; i < n; i++) begin
          a = (bus_addr_t'($urandom) & 16'h0FFF) | ((i % 2) ? PPU_A12 : 16'h0000);
          if ($urandom_range(0, 7) == 0) a[15:13] = 3'($urandom);
          send_access(($urandom_range(0, 5) == 0) ? OP_PPU_PEEK : OP_PPU_READ, a,
                      byte_t'($urandom));
        end
      end
      4, 5: begin
        for (int i = 0; i < 3; i++) begin
          a = bus_addr_t'($urandom);
          if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
          send_access(OP_CPU_READ, a, byte_t'($urandom));
        end
      end
      6: begin
        d = byte_t'($urandom);
        if ($urandom_range(0, 3) != 0) d[7] = 1'b1;
        send_access(OP_CPU_WRITE, reg_addr(MIRROR_BASE, 1'b1), d);
        for (int i = 0; i < 3; i++)
          send_access($urandom_range(0, 1) ? OP_CPU_WRITE : OP_CPU_READ,
                      RAM_BASE | (bus_addr_t'($urandom) & 16'h1FFF), byte_t'($urandom));
      end
      7: begin
        for (int i = 0; i < 2; i++)
          send_access(OP_PPU_PEEK, bus_addr_t'($urandom) & 16'h3FFF, byte_t'($urandom));
      end
      8: begin
        for (int i = 0; i < 3; i++)
          send_access(opcode_t'($urandom_range(0, 3)), bus_addr_t'($urandom),
                      byte_t'($urandom));
      end
      default: begin
        send_access(OP_CPU_WRITE, reg_addr(MIRROR_BASE, 1'b0), byte_t'($urandom));
        send_access(OP_CPU_WRITE, BANK_REG_BASE | bus_addr_t'($urandom), byte_t'($urandom));
      end
    endcase
    no_idle = 1'b0;
  endtask

  // The receiver stops for a long stretch while beats keep coming
  // back to back, so the mapper fills and holds off its input.
  task automatic test_backpressure();
    hold_len = 80;
    no_idle = 1'b1;
    for (int i = 0; i < 24; i++)
      send_access(opcode_t'($urandom_range(0, 3)), bus_addr_t'($urandom), byte_t'($urandom));
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Random traffic under each bank count setting. Counts change only with
  // the mapper drained.
  task automatic test_bank_counts();
    int target_items;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      write_bank_count(REG_PRG_COUNT, PHASE_PRG[p]);
      write_bank_count(REG_CHR_COUNT, PHASE_CHR[p]);
      target_items = items_sent + PHASE_ITEMS;
      while (items_sent < target_items) random_round();
    end
  endtask

  // Result side: draws a stall before each beat (or serves a requested long
  // hold), then takes the beat and checks it on the falling edge.
  initial begin : result_sink
    int stall;
    rsp.ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(negedge clk);
      while (!rsp.valid) @(negedge clk);
      check_result();
      @(posedge clk);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    req.valid       = 1'b0;
    req.opcode      = OP_CPU_READ;
    req.bus_address = '0;
    req.write_byte  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cpu_windows();
    test_bank_select();
    test_work_ram();
    test_scanline_irq();
    test_backpressure();
    test_bank_counts();

    // Everything expected has to come back, and nothing more after it.
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
